// ----- rtl/npv_pkg.sv -----
`timescale 1ns / 1ps

package npv_pkg;

  localparam int unsigned MAX_POINTS_DEF = 4096;
  localparam int unsigned COORD_W        = 24;
  localparam int unsigned SCALAR_W       = 32;
  localparam int unsigned REF_IDX_W      = 20;
  localparam int unsigned MATCH_IDX_W    = 12;
  localparam int unsigned DIST_W         = 50;
  localparam int unsigned CFG_IW         = 2;
  localparam int unsigned CFG_DW         = 21;

  typedef logic signed [COORD_W-1:0]  coord_t;
  typedef logic signed [SCALAR_W-1:0] scalar_t;

  typedef enum logic [1:0] {
    REQ_CLEAR = 2'd0,
    REQ_LOAD  = 2'd1,
    REQ_QUERY = 2'd2
  } req_type_e;

  typedef enum logic [CFG_IW-1:0] {
    CFG_SAME_ORDER = 2'd0,
    CFG_OUTPUT_INT = 2'd1,
    CFG_REF_COUNT  = 2'd2
  } cfg_idx_e;

  // one stored point, as packed into a memory word
  typedef struct packed {
    coord_t  x;
    coord_t  y;
    coord_t  z;
    scalar_t scalar;
  } point_t;

  // distance unit result
  typedef struct packed {
    logic              valid;
    logic [DIST_W-1:0] sq_len;
    scalar_t           scalar;
  } dist_res_t;

endpackage

// ----- rtl/npv_if.sv -----
`timescale 1ns / 1ps

interface npv_req_if;
  import npv_pkg::*;

  logic             valid;
  logic             ready;
  logic [1:0]       req_type;
  coord_t           coord_x;
  coord_t           coord_y;
  coord_t           coord_z;
  scalar_t          scalar_in;
  logic [REF_IDX_W-1:0] ref_index;

  modport source (
    output valid, req_type, coord_x, coord_y, coord_z, scalar_in, ref_index,
    input  ready
  );
  modport sink (
    input  valid, req_type, coord_x, coord_y, coord_z, scalar_in, ref_index,
    output ready
  );
endinterface

interface npv_rsp_if;
  import npv_pkg::*;

  logic                   valid;
  logic                   ready;
  scalar_t                scalar_out;
  logic [MATCH_IDX_W-1:0] match_index;
  logic                   found;
  logic                   overflowed;

  modport source (
    output valid, scalar_out, match_index, found, overflowed,
    input  ready
  );
  modport sink (
    input  valid, scalar_out, match_index, found, overflowed,
    output ready
  );
endinterface

// ----- rtl/nearest_point_value_lookup_unit.sv -----
`timescale 1ns / 1ps

// Nearest point value lookup. Clear beats empty the point set, load beats append
// a point (x, y, z in signed Q15.8 plus a signed Q16.16 scalar) to one
// MAX_POINTS-deep memory, and query beats return the scalar and index of the
// stored point nearest the query point by squared euclidean distance, the
// lowest index winning ties. With same_order set and reference_count equal to
// the stored count, the point at ref_index is returned without a search. The
// search of a query reads one memory word per cycle through a single read
// port, followed by the read and distance pipeline and the result load. One
// beat is in work at a time; a result waits in the output register while the
// next beat is taken. Loads beyond capacity are dropped and set the sticky
// overflowed flag, which only reset clears. The memory needs no clearing pass
// after reset.
module nearest_point_value_lookup_unit #(
  parameter int unsigned MAX_POINTS = npv_pkg::MAX_POINTS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  npv_req_if.sink                    req_i,
  npv_rsp_if.source                  rsp_o,
  input  logic                       cfg_we_i,
  input  logic [npv_pkg::CFG_IW-1:0] cfg_idx_i,
  input  logic [npv_pkg::CFG_DW-1:0] cfg_data_i
);
  import npv_pkg::*;

  localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_RESULT
  } state_e;

  // truncate a Q16.16 value toward zero
  function automatic scalar_t trunc_int(scalar_t v);
    scalar_t r;
    r = {v[SCALAR_W-1:16], 16'h0000};
    if (v[SCALAR_W-1] && (v[15:0] != 16'h0000)) begin
      r = r + scalar_t'(32'h0001_0000);
    end
    return r;
  endfunction

  // configuration registers
  logic              same_order_q;
  logic              output_int_q;
  logic [CFG_DW-1:0] ref_count_q;

  // point set bookkeeping
  logic [CW-1:0] count_q;
  logic          ovf_q;

  // scan control
  state_e        state_q;
  logic [AW-1:0] addr_q;
  logic [AW-1:0] last_q;
  logic          rd_vld_q;
  logic [AW-1:0] rd_idx_q;
  coord_t        qx_q, qy_q, qz_q;

  // running best
  logic              hit_q;
  logic [DIST_W-1:0] best_d_q;
  logic [AW-1:0]     best_idx_q;
  scalar_t           best_sc_q;

  // output register
  logic                   rsp_vld_q;
  scalar_t                rsp_sc_q;
  logic [MATCH_IDX_W-1:0] rsp_idx_q;
  logic                   rsp_found_q;
  logic                   rsp_ovf_q;

  logic          req_acc;
  logic          is_query;
  logic          can_load;
  logic          ram_we;
  point_t        wr_pt;
  point_t        rd_pt;
  dist_res_t     dres;
  logic [AW-1:0] dres_idx;
  logic          dist_busy;
  logic [31:0]   best_idx_ext;

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_acc     = req_i.valid && req_i.ready;
  assign is_query    = req_acc && (req_i.req_type == REQ_QUERY);
  assign can_load    = (count_q < CW'(MAX_POINTS));
  assign ram_we      = req_acc && (req_i.req_type == REQ_LOAD) && can_load;

  assign wr_pt.x      = req_i.coord_x;
  assign wr_pt.y      = req_i.coord_y;
  assign wr_pt.z      = req_i.coord_z;
  assign wr_pt.scalar = req_i.scalar_in;

  // configuration writes, unknown indexes ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      same_order_q <= 1'b0;
      output_int_q <= 1'b0;
      ref_count_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SAME_ORDER: same_order_q <= cfg_data_i[0];
        CFG_OUTPUT_INT: output_int_q <= cfg_data_i[0];
        CFG_REF_COUNT:  ref_count_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // fill count and sticky overflow; clear keeps the flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else if (req_acc) begin
      unique case (req_i.req_type)
        REQ_CLEAR: count_q <= '0;
        REQ_LOAD: begin
          if (can_load) begin
            count_q <= count_q + CW'(1);
          end else begin
            ovf_q <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // point memory, one word per point
  npv_ram #(
    .WIDTH ($bits(point_t)),
    .DEPTH (MAX_POINTS)
  ) u_point_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (wr_pt),
    .raddr_i (addr_q),
    .rdata_o (rd_pt)
  );

  npv_dist #(
    .AW (AW)
  ) u_dist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (rd_vld_q),
    .pt_i   (rd_pt),
    .idx_i  (rd_idx_q),
    .qx_i   (qx_q),
    .qy_i   (qy_q),
    .qz_i   (qz_q),
    .res_o  (dres),
    .idx_o  (dres_idx),
    .busy_o (dist_busy)
  );

  // first strictly smaller distance wins, so ties keep the lower index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else if (is_query) begin
      hit_q <= 1'b0;
    end else if (dres.valid && (!hit_q || (dres.sq_len < best_d_q))) begin
      hit_q      <= 1'b1;
      best_d_q   <= dres.sq_len;
      best_idx_q <= dres_idx;
      best_sc_q  <= dres.scalar;
    end
  end

  assign best_idx_ext = 32'(best_idx_q);

  // sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      rsp_vld_q <= 1'b0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (rsp_vld_q && rsp_o.ready) begin
        rsp_vld_q <= 1'b0;
      end
      rd_vld_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (is_query) begin
            qx_q <= req_i.coord_x;
            qy_q <= req_i.coord_y;
            qz_q <= req_i.coord_z;
            if (same_order_q && (ref_count_q == CFG_DW'(count_q))) begin
              // pointwise correspondence: a one-entry scan at ref_index
              if (CFG_DW'(req_i.ref_index) < CFG_DW'(count_q)) begin
                addr_q  <= req_i.ref_index[AW-1:0];
                last_q  <= req_i.ref_index[AW-1:0];
                state_q <= ST_SCAN;
              end else begin
                state_q <= ST_RESULT;
              end
            end else if (count_q == '0) begin
              state_q <= ST_RESULT;
            end else begin
              addr_q  <= '0;
              last_q  <= AW'(count_q - CW'(1));
              state_q <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          rd_vld_q <= 1'b1;
          rd_idx_q <= addr_q;
          if (addr_q == last_q) begin
            state_q <= ST_DRAIN;
          end else begin
            addr_q <= addr_q + AW'(1);
          end
        end
        ST_DRAIN: begin
          // wait for the last read to leave the distance pipeline
          if (!rd_vld_q && !dist_busy) begin
            state_q <= ST_RESULT;
          end
        end
        ST_RESULT: begin
          if (!rsp_vld_q || rsp_o.ready) begin
            rsp_vld_q   <= 1'b1;
            rsp_found_q <= hit_q;
            rsp_ovf_q   <= ovf_q;
            if (hit_q) begin
              rsp_sc_q  <= output_int_q ? trunc_int(best_sc_q) : best_sc_q;
              rsp_idx_q <= best_idx_ext[MATCH_IDX_W-1:0];
            end else begin
              rsp_sc_q  <= '0;
              rsp_idx_q <= '0;
            end
            state_q <= ST_IDLE;
          end
        end
      endcase
    end
  end

  assign rsp_o.valid       = rsp_vld_q;
  assign rsp_o.scalar_out  = rsp_sc_q;
  assign rsp_o.match_index = rsp_idx_q;
  assign rsp_o.found       = rsp_found_q;
  assign rsp_o.overflowed  = rsp_ovf_q;

endmodule

// ----- rtl/npv_ram.sv -----
`timescale 1ns / 1ps

module npv_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/npv_dist.sv -----
`timescale 1ns / 1ps

module npv_dist #(
  parameter int unsigned AW = 12
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               vld_i,
  input  npv_pkg::point_t    pt_i,
  input  logic [AW-1:0]      idx_i,
  input  npv_pkg::coord_t    qx_i,
  input  npv_pkg::coord_t    qy_i,
  input  npv_pkg::coord_t    qz_i,
  output npv_pkg::dist_res_t res_o,
  output logic [AW-1:0]      idx_o,
  output logic               busy_o
);
  import npv_pkg::*;

  localparam int unsigned NSTG = 4;
  localparam int unsigned SQ_W = 2 * COORD_W;

  function automatic logic [COORD_W-1:0] abs_diff(coord_t a, coord_t b);
    logic signed [COORD_W:0] d;
    d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    return d[COORD_W] ? COORD_W'(-d) : COORD_W'(d);
  endfunction

  logic [NSTG-1:0]    vld_q;
  scalar_t            sc_q  [NSTG];
  logic [AW-1:0]      idx_q [NSTG];

  logic [COORD_W-1:0] ad0_q, ad1_q, ad2_q;
  logic [SQ_W-1:0]    sq0_q, sq1_q, sq2_q, sq2_dly_q;
  logic [SQ_W:0]      p01_q;
  logic [DIST_W-1:0]  dist_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[NSTG-2:0], vld_i};
    end
  end

  // stage 1 abs diffs, stage 2 squares, stage 3 partial sum, stage 4 total
  always_ff @(posedge clk_i) begin
    ad0_q     <= abs_diff(qx_i, pt_i.x);
    ad1_q     <= abs_diff(qy_i, pt_i.y);
    ad2_q     <= abs_diff(qz_i, pt_i.z);
    sq0_q     <= {{COORD_W{1'b0}}, ad0_q} * {{COORD_W{1'b0}}, ad0_q};
    sq1_q     <= {{COORD_W{1'b0}}, ad1_q} * {{COORD_W{1'b0}}, ad1_q};
    sq2_q     <= {{COORD_W{1'b0}}, ad2_q} * {{COORD_W{1'b0}}, ad2_q};
    p01_q     <= {1'b0, sq0_q} + {1'b0, sq1_q};
    sq2_dly_q <= sq2_q;
    dist_q    <= DIST_W'({1'b0, p01_q}) + DIST_W'(sq2_dly_q);
    sc_q[0]   <= pt_i.scalar;
    idx_q[0]  <= idx_i;
    for (int i = 1; i < NSTG; i++) begin
      sc_q[i]  <= sc_q[i-1];
      idx_q[i] <= idx_q[i-1];
    end
  end

  assign res_o.valid  = vld_q[NSTG-1];
  assign res_o.sq_len = dist_q;
  assign res_o.scalar = sc_q[NSTG-1];
  assign idx_o        = idx_q[NSTG-1];
  assign busy_o       = |vld_q;

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import npv_pkg::*;

  // timing of the bench
  localparam int unsigned CLK_HALF_NS      = 2;
  localparam int unsigned RESET_CYCLES     = 5;
  localparam int unsigned MAX_WAIT         = 12;
  localparam int unsigned SETTLE_CYCLES    = 16;
  localparam int unsigned DRAIN_CYCLES     = 32;
  localparam int unsigned HOLD_CYCLES      = 300;  // long receiver hold-off
  localparam int unsigned RUN_LIMIT_CYCLES = 100_000;

  // stimulus sizing
  localparam int unsigned RANDOM_BEATS = 110;
  localparam int unsigned STORE_DEPTH  = MAX_POINTS_DEF;

  localparam logic [1:0]        REQ_UNKNOWN   = 2'd3;
  localparam coord_t            COORD_MIN     = {1'b1, {(COORD_W-1){1'b0}}};
  localparam coord_t            COORD_MAX     = {1'b0, {(COORD_W-1){1'b1}}};
  localparam scalar_t           SCALAR_MIN    = {1'b1, {(SCALAR_W-1){1'b0}}};
  localparam scalar_t           SCALAR_MAX    = {1'b0, {(SCALAR_W-1){1'b1}}};
  localparam logic [CFG_DW-1:0] REF_COUNT_MAX = 21'd1048576;

  // one request beat as the bench keeps it
  typedef struct {
    logic [1:0]           kind;
    coord_t               x;
    coord_t               y;
    coord_t               z;
    scalar_t              scalar;
    logic [REF_IDX_W-1:0] ref_index;
    bit                   drain_first;  // sender waits until all lookups have returned
  } lookup_req_t;

  // one lookup result
  typedef struct {
    scalar_t                scalar;
    logic [MATCH_IDX_W-1:0] index;
    logic                   found;
    logic                   overflowed;
  } lookup_rsp_t;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [CFG_IW-1:0] cfg_idx_i;
  logic [CFG_DW-1:0] cfg_data_i;

  npv_req_if req_if ();
  npv_rsp_if rsp_if ();

  nearest_point_value_lookup_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_if),
    .rsp_o      (rsp_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // request beats waiting for the driver, lookups waiting for the block
  lookup_req_t pending_reqs[$];
  lookup_rsp_t expected_lookups[$];

  // shadow of the point store, filled at request acceptance
  coord_t      pt_x [STORE_DEPTH];
  coord_t      pt_y [STORE_DEPTH];
  coord_t      pt_z [STORE_DEPTH];
  scalar_t     pt_scalar [STORE_DEPTH];
  int unsigned pt_count;
  bit          store_overflow;

  // shadow of the registers
  bit                cfg_same_order;
  bit                cfg_output_int;
  logic [CFG_DW-1:0] cfg_ref_count;

  // what the stimulus has planned so far, used to aim queries at stored points
  coord_t      plan_x [STORE_DEPTH];
  coord_t      plan_y [STORE_DEPTH];
  coord_t      plan_z [STORE_DEPTH];
  int unsigned plan_count;

  // idling controls shared with the driver and the receiver
  bit          sender_burst;
  bit          receiver_burst;
  int unsigned hold_req;
  int unsigned hold_ack;
  int unsigned send_wait;
  int unsigned take_wait;
  int unsigned next_take;

  // bookkeeping
  int unsigned beats_queued;
  int unsigned beats_accepted;
  int unsigned useful_beats;
  int unsigned results_checked;
  int unsigned mismatches;
  int unsigned n_loads;
  int unsigned n_dropped;
  int unsigned n_queries;
  int unsigned n_found;
  int unsigned n_clears;
  int unsigned n_ignored;

  // -------------------------------------------------------------------------
  // prediction
  // -------------------------------------------------------------------------

  function automatic longint sq_diff(coord_t a, coord_t b);
    longint d;
    d = longint'(a) - longint'(b);
    return d * d;
  endfunction

  // signed division already rounds toward zero
  function automatic longint trunc_toward_zero(longint v);
    return (v / 65536) * 65536;
  endfunction

  // apply one accepted beat to the shadow store and queue its lookup result
  function automatic void nearest_point_step(lookup_req_t r);
    lookup_rsp_t res;
    longint      best_len;
    longint      len;
    int unsigned best;
    bit          hit;
    longint      value;
    hit      = 1'b0;
    best     = 0;
    best_len = 0;
    value    = 0;
    case (r.kind)
      REQ_CLEAR: begin
        pt_count = 0;
        n_clears++;
      end
      REQ_LOAD: begin
        n_loads++;
        if (pt_count < STORE_DEPTH) begin
          pt_x[pt_count]      = r.x;
          pt_y[pt_count]      = r.y;
          pt_z[pt_count]      = r.z;
          pt_scalar[pt_count] = r.scalar;
          pt_count++;
        end else begin
          store_overflow = 1'b1;
          n_dropped++;
        end
      end
      REQ_QUERY: begin
        n_queries++;
        if (cfg_same_order && 32'(cfg_ref_count) == pt_count) begin
          // pointwise correspondence, no search
          if (32'(r.ref_index) < pt_count) begin
            hit  = 1'b1;
            best = 32'(r.ref_index);
          end
        end else begin
          // full scan, only a strictly shorter distance replaces the best
          for (int unsigned i = 0; i < pt_count; i++) begin
            len = sq_diff(r.x, pt_x[i]) + sq_diff(r.y, pt_y[i]) + sq_diff(r.z, pt_z[i]);
            if (!hit || len < best_len) begin
              hit      = 1'b1;
              best     = i;
              best_len = len;
            end
          end
        end
        if (hit) begin
          value = longint'(pt_scalar[best]);
          if (cfg_output_int) value = trunc_toward_zero(value);
          n_found++;
        end
        res.scalar     = scalar_t'(value);
        res.index      = best[MATCH_IDX_W-1:0];
        res.found      = hit;
        res.overflowed = store_overflow;
        expected_lookups.push_back(res);
      end
      default: n_ignored++;
    endcase
  endfunction

  // -------------------------------------------------------------------------
  // checking
  // -------------------------------------------------------------------------

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at %0t ns: %s got 0x%08h want 0x%08h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic check_lookup(lookup_rsp_t got);
    lookup_rsp_t want;
    if (expected_lookups.size() == 0) begin
      report_mismatch("result with no query pending", got.scalar, '0);
      return;
    end
    want = expected_lookups.pop_front();
    results_checked++;
    if (got.scalar !== want.scalar)
      report_mismatch("scalar_out", got.scalar, want.scalar);
    if (got.index !== want.index)
      report_mismatch("match_index", 32'(got.index), 32'(want.index));
    if (got.found !== want.found)
      report_mismatch("found", 32'(got.found), 32'(want.found));
    if (got.overflowed !== want.overflowed)
      report_mismatch("overflowed", 32'(got.overflowed), 32'(want.overflowed));
  endtask

  // -------------------------------------------------------------------------
  // clock, reset, run limit
  // -------------------------------------------------------------------------

  initial begin
    clk_i = 1'b0;
    forever #(CLK_HALF_NS) clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // hard stop in case the block hangs
  initial begin
    #(RUN_LIMIT_CYCLES * 2 * CLK_HALF_NS);
    $display("timeout with %0d lookups outstanding", expected_lookups.size());
    $display("RESULT: ERROR");
    $finish;
  end

  // -------------------------------------------------------------------------
  // idle draws
  // -------------------------------------------------------------------------

  // burst beats go back to back; otherwise a third go back to back, the rest wait up to MAX_WAIT
  function automatic int unsigned draw_wait(bit burst);
    if (burst || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, MAX_WAIT);
  endfunction

  // -------------------------------------------------------------------------
  // request driver: also predicts on every accepted beat
  // -------------------------------------------------------------------------

  always @(posedge clk_i or negedge rst_ni) begin : req_driver
    lookup_req_t head;
    lookup_req_t seen;
    if (!rst_ni) begin
      req_if.valid     <= 1'b0;
      req_if.req_type  <= REQ_CLEAR;
      req_if.coord_x   <= '0;
      req_if.coord_y   <= '0;
      req_if.coord_z   <= '0;
      req_if.scalar_in <= '0;
      req_if.ref_index <= '0;
      send_wait        <= 0;
    end else begin
      // accepted beat: update the shadow before anything else
      if (req_if.valid && req_if.ready) begin
        seen.kind        = req_if.req_type;
        seen.x           = req_if.coord_x;
        seen.y           = req_if.coord_y;
        seen.z           = req_if.coord_z;
        seen.scalar      = req_if.scalar_in;
        seen.ref_index   = req_if.ref_index;
        seen.drain_first = 1'b0;
        nearest_point_step(seen);
        beats_accepted++;
      end
      // the slot is free unless a beat is still being offered
      if (!req_if.valid || req_if.ready) begin
        if (send_wait != 0) begin
          req_if.valid <= 1'b0;
          send_wait    <= send_wait - 1;
        end else if (pending_reqs.size() == 0) begin
          req_if.valid <= 1'b0;
        end else if (pending_reqs[0].drain_first && expected_lookups.size() != 0) begin
          // pause until every outstanding lookup has come back
          req_if.valid <= 1'b0;
        end else begin
          head = pending_reqs.pop_front();
          req_if.valid     <= 1'b1;
          req_if.req_type  <= head.kind;
          req_if.coord_x   <= head.x;
          req_if.coord_y   <= head.y;
          req_if.coord_z   <= head.z;
          req_if.scalar_in <= head.scalar;
          req_if.ref_index <= head.ref_index;
          send_wait        <= draw_wait(sender_burst);
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // result receiver: random stalls, plus a long hold-off on request
  // -------------------------------------------------------------------------

  always @(posedge clk_i or negedge rst_ni) begin : rsp_receiver
    lookup_rsp_t got;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      take_wait    <= 0;
      hold_ack     <= 0;
    end else begin
      next_take = take_wait;
      if (rsp_if.valid && rsp_if.ready) begin
        got.scalar     = rsp_if.scalar_out;
        got.index      = rsp_if.match_index;
        got.found      = rsp_if.found;
        got.overflowed = rsp_if.overflowed;
        check_lookup(got);
        next_take = draw_wait(receiver_burst);
      end else if (next_take != 0) begin
        next_take = next_take - 1;
      end
      // long stall so the block fills up and backs up its input
      if (hold_ack != hold_req) begin
        hold_ack  <= hold_req;
        next_take = HOLD_CYCLES;
      end
      take_wait    <= next_take;
      rsp_if.ready <= (next_take == 0);
    end
  end

  // -------------------------------------------------------------------------
  // stimulus helpers
  // -------------------------------------------------------------------------

  function automatic coord_t rand_coord();
    coord_t c;
    case ($urandom_range(0, 7))
      0: c = COORD_MIN;
      1: c = COORD_MAX;
      2, 3, 4: c = coord_t'($urandom_range(0, 127)) - coord_t'(64);  // dense cluster, many ties
      default: c = coord_t'($urandom);
    endcase
    return c;
  endfunction

  function automatic scalar_t rand_scalar();
    scalar_t s;
    case ($urandom_range(0, 5))
      0: s = SCALAR_MIN;
      1: s = SCALAR_MAX;
      2: s = scalar_t'(-($urandom_range(1, 500) * 65536));  // negative whole number
      default: s = scalar_t'($urandom);
    endcase
    return s;
  endfunction

  // in range, one past the end, or anywhere in the 20-bit field
  function automatic logic [REF_IDX_W-1:0] rand_ref_index();
    logic [REF_IDX_W-1:0] r;
    case ($urandom_range(0, 3))
      0: r = REF_IDX_W'($urandom);
      1: r = REF_IDX_W'(plan_count);
      default: r = (plan_count == 0) ? '0 : REF_IDX_W'($urandom_range(0, plan_count - 1));
    endcase
    return r;
  endfunction

  function automatic void queue_beat(logic [1:0] kind, coord_t x, coord_t y, coord_t z,
                                     scalar_t s, logic [REF_IDX_W-1:0] ridx, bit drain);
    lookup_req_t r;
    r.kind        = kind;
    r.x           = x;
    r.y           = y;
    r.z           = z;
    r.scalar      = s;
    r.ref_index   = ridx;
    r.drain_first = drain;
    pending_reqs.push_back(r);
    beats_queued++;
    if (kind != REQ_UNKNOWN) useful_beats++;
    if (kind == REQ_CLEAR) begin
      plan_count = 0;
    end else if (kind == REQ_LOAD && plan_count < STORE_DEPTH) begin
      plan_x[plan_count] = x;
      plan_y[plan_count] = y;
      plan_z[plan_count] = z;
      plan_count++;
    end
  endfunction

  function automatic void queue_load(coord_t x, coord_t y, coord_t z, scalar_t s);
    queue_beat(REQ_LOAD, x, y, z, s, rand_ref_index(), 1'b0);
  endfunction

  function automatic void queue_query(coord_t x, coord_t y, coord_t z,
                                      logic [REF_IDX_W-1:0] ridx);
    queue_beat(REQ_QUERY, x, y, z, rand_scalar(), ridx, 1'b0);
  endfunction

  function automatic void queue_clear();
    queue_beat(REQ_CLEAR, rand_coord(), rand_coord(), rand_coord(), rand_scalar(),
               rand_ref_index(), 1'b0);
  endfunction

  function automatic void queue_unknown();
    queue_beat(REQ_UNKNOWN, rand_coord(), rand_coord(), rand_coord(), rand_scalar(),
               rand_ref_index(), 1'b0);
  endfunction

  // half the queries land close to a planned point, the rest anywhere
  function automatic void queue_rand_query(bit drain);
    coord_t      qx;
    coord_t      qy;
    coord_t      qz;
    int unsigned j;
    if (plan_count != 0 && $urandom_range(0, 1) == 1) begin
      j  = $urandom_range(0, plan_count - 1);
      qx = plan_x[j] + coord_t'($urandom_range(0, 8)) - coord_t'(4);
      qy = plan_y[j] + coord_t'($urandom_range(0, 8)) - coord_t'(4);
      qz = plan_z[j] + coord_t'($urandom_range(0, 8)) - coord_t'(4);
    end else begin
      qx = rand_coord();
      qy = rand_coord();
      qz = rand_coord();
    end
    queue_beat(REQ_QUERY, qx, qy, qz, rand_scalar(), rand_ref_index(), drain);
  endfunction

  // register write, only issued while the block is idle
  task automatic write_reg(cfg_idx_e idx, logic [CFG_DW-1:0] value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_SAME_ORDER: cfg_same_order = value[0];
      CFG_OUTPUT_INT: cfg_output_int = value[0];
      CFG_REF_COUNT:  cfg_ref_count  = value;
      default: ;
    endcase
  endtask

  // every queued beat taken, every lookup back, then let loads and clears settle
  task automatic wait_idle();
    while (beats_accepted != beats_queued || expected_lookups.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // -------------------------------------------------------------------------
  // test sequence
  // -------------------------------------------------------------------------

  initial begin : stimulus
    int unsigned directed_beats;
    int unsigned round;
    int unsigned n_round_loads;
    int unsigned n_round_queries;
    int unsigned round_count;
    bit          do_clear;
    bit          pressure;

    // known values on every input from time zero
    cfg_we_i         = 1'b0;
    cfg_idx_i        = CFG_SAME_ORDER;
    cfg_data_i       = '0;
    req_if.valid     = 1'b0;
    req_if.req_type  = REQ_CLEAR;
    req_if.coord_x   = '0;
    req_if.coord_y   = '0;
    req_if.coord_z   = '0;
    req_if.scalar_in = '0;
    req_if.ref_index = '0;
    rsp_if.ready     = 1'b0;

    pt_count       = 0;
    store_overflow = 1'b0;
    cfg_same_order = 1'b0;
    cfg_output_int = 1'b0;
    cfg_ref_count  = '0;
    plan_count     = 0;
    sender_burst   = 1'b0;
    receiver_burst = 1'b0;
    hold_req       = 0;

    wait (rst_ni === 1'b1);
    @(posedge clk_i);

    // --- directed: empty set, ignored request, extremes, ties ---
    queue_query('0, '0, '0, '0);                                  // empty set, not found
    queue_unknown();                                              // ignored, no result
    queue_load(COORD_MIN, COORD_MIN, COORD_MIN, SCALAR_MAX);      // index 0
    queue_load(COORD_MAX, COORD_MAX, COORD_MAX, SCALAR_MIN);      // index 1
    queue_load('0, '0, '0, scalar_t'(-98304));                    // index 2, -1.5
    queue_load(coord_t'(512), '0, '0, scalar_t'(32'h0002_8000));  // index 3, 2.5
    queue_load('0, '0, '0, scalar_t'(32'h1234_5678));             // index 4, duplicate of 2
    queue_query(COORD_MIN, COORD_MIN, COORD_MIN, '0);             // far corner
    queue_query(COORD_MAX, COORD_MAX, COORD_MAX, '0);             // opposite corner
    queue_query(coord_t'(256), '0, '0, '0);                       // equidistant, lower index wins
    queue_query('0, '0, '0, '0);                                  // exact duplicate, lower wins
    queue_query(coord_t'(600), coord_t'(-3), coord_t'(7), '0);

    // integer output: truncation toward zero on both signs
    wait_idle();
    write_reg(CFG_OUTPUT_INT, CFG_DW'(1));
    queue_query(coord_t'(256), '0, '0, '0);
    queue_query(COORD_MAX, COORD_MAX, COORD_MAX, '0);
    queue_query(COORD_MIN, COORD_MIN, COORD_MIN, '0);
    queue_query(coord_t'(600), coord_t'(-3), coord_t'(7), '0);

    // same-order with matching counts: index used directly
    wait_idle();
    write_reg(CFG_SAME_ORDER, CFG_DW'(1));
    write_reg(CFG_REF_COUNT, 21'd5);
    queue_query(COORD_MIN, '0, '0, 20'd4);
    queue_query('0, '0, '0, 20'd5);                               // index past the set
    queue_query('0, '0, '0, 20'hFFFFF);                           // widest index
    queue_query(COORD_MAX, COORD_MAX, COORD_MAX, 20'd0);          // no search despite distance

    // counts differ: back to the search
    wait_idle();
    write_reg(CFG_REF_COUNT, 21'd4);
    queue_query('0, '0, '0, 20'd4);
    queue_clear();
    queue_query('0, '0, '0, '0);                                  // empty after clear

    // same-order with an empty set and zero reference count
    wait_idle();
    write_reg(CFG_REF_COUNT, '0);
    queue_query('0, '0, '0, '0);
    directed_beats = useful_beats;

    // --- random rounds: clear now and then, load a handful, query ---
    round = 0;
    while (useful_beats < directed_beats + RANDOM_BEATS) begin
      pressure        = (round == 2 || round == 6);
      do_clear        = (plan_count > 40) || ($urandom_range(0, 1) == 1);
      n_round_loads   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
      n_round_queries = pressure ? 8 : $urandom_range(1, 6);
      round_count     = (do_clear ? 0 : plan_count) + n_round_loads;

      // reconfigure most rounds, otherwise keep streaming without a pause
      if (pressure || $urandom_range(0, 2) != 0) begin
        wait_idle();
        if ($urandom_range(0, 1) == 1) write_reg(CFG_SAME_ORDER, CFG_DW'($urandom_range(0, 1)));
        if ($urandom_range(0, 2) == 0) write_reg(CFG_OUTPUT_INT, CFG_DW'($urandom_range(0, 1)));
        case ($urandom_range(0, 7))
          0: write_reg(CFG_REF_COUNT, '0);
          1: write_reg(CFG_REF_COUNT, REF_COUNT_MAX);
          2: write_reg(CFG_REF_COUNT, CFG_DW'($urandom_range(0, REF_COUNT_MAX)));
          3: write_reg(CFG_REF_COUNT, CFG_DW'(round_count + 1));
          default: write_reg(CFG_REF_COUNT, CFG_DW'(round_count));   // counts match at query time
        endcase
      end

      sender_burst   = pressure || ($urandom_range(0, 3) == 0);
      receiver_burst = ($urandom_range(0, 3) == 0);
      if (pressure) hold_req++;

      if (do_clear) queue_clear();
      for (int unsigned i = 0; i < n_round_loads; i++) begin
        queue_load(rand_coord(), rand_coord(), rand_coord(), rand_scalar());
        // an early query now and then sees a partial set
        if ($urandom_range(0, 7) == 0) queue_rand_query(1'b0);
      end
      if ($urandom_range(0, 5) == 0) queue_unknown();
      for (int unsigned i = 0; i < n_round_queries; i++)
        queue_rand_query(i == 0 && $urandom_range(0, 3) == 0);
      round++;
    end

    // --- clear and refill, the sender waits for every result before the last query ---
    wait_idle();
    sender_burst = 1'b0;
    queue_clear();
    queue_query(rand_coord(), rand_coord(), rand_coord(), '0);
    queue_load(rand_coord(), rand_coord(), rand_coord(), rand_scalar());
    queue_load(rand_coord(), rand_coord(), rand_coord(), rand_scalar());
    queue_rand_query(1'b1);

    // --- wrap up ---
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d beats: %0d loads (%0d dropped when full), %0d clears, %0d ignored",
             beats_accepted, n_loads, n_dropped, n_clears, n_ignored);
    $display("%0d queries, %0d hits, %0d results checked, %0d mismatches",
             n_queries, n_found, results_checked, mismatches);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
